// File: hdl/atau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atau_pkg
// shared constants, command codes, control structs and helper functions
// ----------------------------------------------------------------------------
package atau_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int ROOT_STEPS       = 24;
   localparam int NUM_REGS         = 3;

   localparam logic [1:0] CMD_MEASURE   = 2'd0;
   localparam logic [1:0] CMD_CALIBRATE = 2'd1;
   localparam logic [1:0] CMD_LOAD      = 2'd2;
   localparam logic [1:0] CMD_SPARE     = 2'd3;

   localparam logic [1:0] REG_PHI_OFFSET   = 2'd0;
   localparam logic [1:0] REG_THETA_OFFSET = 2'd1;
   localparam logic [1:0] REG_PSI_OFFSET   = 2'd2;

   localparam logic [1:0] SEL_PHI   = 2'd0;
   localparam logic [1:0] SEL_THETA = 2'd1;
   localparam logic [1:0] SEL_PSI   = 2'd2;

   localparam logic signed [17:0] ANGLE_LIMIT = 18'sd18000;
   localparam logic [15:0]        QUARTER     = 16'd9000;
   localparam logic [15:0]        TEMP_RECIP  = 16'd61681;   // ceil(2^20 / 17)
   localparam logic signed [15:0] TEMP_BIAS   = 16'sd3653;

   typedef struct packed {
      logic       capture;
      logic       square;
      logic [1:0] sq_idx;
      logic       root_init;
      logic       root_step;
      logic       cor_init;
      logic       cor_step;
      logic [4:0] iter;
      logic [1:0] sel;
      logic       store;
      logic       apply;
      logic       out_load;
   } atau_cmd_type;

   typedef struct packed {
      logic trivial;
   } atau_status_type;

   // round(atan(2^-i) * 100 * 2^16), degrees
   function automatic logic [28:0] atan_entry(input logic [4:0] i);
      logic [28:0] r;
      unique case (i)
         5'd0:  r = 29'd294912000;
         5'd1:  r = 29'd174096719;
         5'd2:  r = 29'd91987925;
         5'd3:  r = 29'd46694507;
         5'd4:  r = 29'd23437865;
         5'd5:  r = 29'd11730358;
         5'd6:  r = 29'd5866610;
         5'd7:  r = 29'd2933484;
         5'd8:  r = 29'd1466764;
         5'd9:  r = 29'd733385;
         5'd10: r = 29'd366693;
         5'd11: r = 29'd183346;
         5'd12: r = 29'd91673;
         5'd13: r = 29'd45837;
         5'd14: r = 29'd22918;
         5'd15: r = 29'd11459;
         5'd16: r = 29'd5730;
         5'd17: r = 29'd2865;
         5'd18: r = 29'd1432;
         5'd19: r = 29'd716;
         5'd20: r = 29'd358;
         5'd21: r = 29'd179;
         5'd22: r = 29'd90;
         5'd23: r = 29'd45;
         default: r = 29'd0;
      endcase
      return r;
   endfunction

   // clamp to +-180 degrees in centidegrees
   function automatic logic signed [15:0] sat_angle(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > ANGLE_LIMIT) begin
         r = 16'sd18000;
      end else if (v < -ANGLE_LIMIT) begin
         r = -16'sd18000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/accel_tilt_angle_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angle_unit_core
// tilt angles (phi, theta, psi) and temperature from one accelerometer sample
// ----------------------------------------------------------------------------
// usage:
//  - req_ channel: one transfer when req_valid is high and req_stall low, carrying
//    the command plus raw x, y, z and temperature words
//  - rsp_ channel: one result per request, taken when rsp_valid is high and
//    rsp_stall low; the output register holds it while stalled
//  - csr_ channel: register writes (index 0..2 offsets), always ready
//  - one item in flight; the next request can be taken in the cycle in which
//    rsp_valid rises. The steps per item are a capture, three squares on one
//    multiplier, then per angle a bit-serial square root of 24 result bits plus
//    a 16-step cordic pass on one shared unit; angles with a zero numerator or
//    denominator skip both
//  - throughput is set by the shared root and cordic units
//  - a finished result waits in the output register if the receiver stalls; the
//    next request is taken once the previous result has been loaded there
//  - reset (synchronous) clears offsets, config registers and all control state
// ----------------------------------------------------------------------------
module accel_tilt_angle_unit_core
   import atau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_temp_raw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_phi_angle,
   output logic signed [15:0] rsp_theta_angle,
   output logic signed [15:0] rsp_psi_angle,
   output logic signed [14:0] rsp_temperature_centi,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   atau_cmd_type    cmd;
   atau_status_type status;

   // registers are plain flops, a write is taken every cycle
   assign csr_ready = 1'b1;

   // sequencer
   atau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, offsets and result registers
   atau_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_cmd               (req_cmd),
      .req_accel_x           (req_accel_x),
      .req_accel_y           (req_accel_y),
      .req_accel_z           (req_accel_z),
      .req_temp_raw          (req_temp_raw),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_phi_angle         (rsp_phi_angle),
      .rsp_theta_angle       (rsp_theta_angle),
      .rsp_psi_angle         (rsp_psi_angle),
      .rsp_temperature_centi (rsp_temperature_centi)
   );

endmodule

// File: hdl/atau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atau_datapath
// squares, bit-serial square root, shared cordic, offsets and result registers
// ----------------------------------------------------------------------------
module atau_datapath
   import atau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  atau_cmd_type        cmd,
   output atau_status_type     status,
   input  logic [1:0]          req_cmd,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_temp_raw,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic signed [15:0]  rsp_phi_angle,
   output logic signed [15:0]  rsp_theta_angle,
   output logic signed [15:0]  rsp_psi_angle,
   output logic signed [14:0]  rsp_temperature_centi
);

   logic [1:0]         cmd_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [17:0]        temp_mag_ff;
   logic               temp_neg_ff;
   logic [33:0]        temp_prod_ff;
   logic [30:0]        sq_ff [3];
   logic [47:0]        rad_ff;
   logic [25:0]        rem_ff;
   logic [23:0]        root_ff;
   logic signed [27:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic signed [14:0] ang_ff [3];
   logic signed [15:0] off_ff [3];
   logic [15:0]        cfg_ff [3];
   logic signed [15:0] out_ang_ff [3];
   logic signed [14:0] temp_out_ff;

   // ---- capture
   logic signed [18:0] tr5;
   assign tr5 = {req_temp_raw[15], req_temp_raw, 2'b00}
              + {{3{req_temp_raw[15]}}, req_temp_raw};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_cmd;
         ax_ff       <= req_accel_x;
         ay_ff       <= req_accel_y;
         az_ff       <= req_accel_z;
         temp_neg_ff <= tr5[18];
         temp_mag_ff <= tr5[18] ? 18'(-tr5) : tr5[17:0];
      end
   end

   // ---- squares on one shared multiplier
   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   always_comb begin
      unique case (cmd.sq_idx)
         2'd0:    sq_op = ax_ff;
         2'd1:    sq_op = ay_ff;
         default: sq_op = az_ff;
      endcase
      sq_prod = sq_op * sq_op;
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff[cmd.sq_idx] <= sq_prod[30:0];
         temp_prod_ff      <= temp_mag_ff * TEMP_RECIP;
      end
   end

   // ---- per-angle selection
   logic num_zero, den_zero, num_neg, den_neg;
   logic [31:0] rad_sum;
   logic [15:0] abs_x, abs_y, abs_z;
   assign abs_x = ax_ff[15] ? 16'(-ax_ff) : ax_ff;
   assign abs_y = ay_ff[15] ? 16'(-ay_ff) : ay_ff;
   assign abs_z = az_ff[15] ? 16'(-az_ff) : az_ff;

   always_comb begin
      unique case (cmd.sel)
         SEL_PHI: begin
            num_zero = (ax_ff == '0) && (ay_ff == '0);
            den_zero = (az_ff == '0);
            num_neg  = 1'b0;
            den_neg  = az_ff[15];
            rad_sum  = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
         end
         SEL_THETA: begin
            num_zero = (ax_ff == '0);
            den_zero = (ay_ff == '0) && (az_ff == '0);
            num_neg  = ax_ff[15];
            den_neg  = 1'b0;
            rad_sum  = {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]};
         end
         default: begin
            num_zero = (ay_ff == '0);
            den_zero = (ax_ff == '0) && (az_ff == '0);
            num_neg  = ay_ff[15];
            den_neg  = 1'b0;
            rad_sum  = {1'b0, sq_ff[0]} + {1'b0, sq_ff[2]};
         end
      endcase
   end
   assign status.trivial = num_zero | den_zero;

   // ---- restoring square root, one result bit per cycle
   logic [27:0] rem_sh, trial;
   assign rem_sh = {rem_ff, rad_ff[47:46]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rad_ff  <= {rad_sum, 16'h0000};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[45:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= 26'(rem_sh - trial);
            root_ff <= {root_ff[22:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[25:0];
            root_ff <= {root_ff[22:0], 1'b0};
         end
      end
   end

   // ---- vectoring cordic
   logic signed [27:0] y_mag;
   logic signed [27:0] x_sh;
   logic signed [31:0] atan_w;
   assign y_mag  = y_ff[27] ? -y_ff : y_ff;
   assign x_sh   = x_ff >>> cmd.iter;
   assign atan_w = {3'b000, atan_entry(cmd.iter)};

   always_ff @(posedge clock) begin
      if (cmd.cor_init) begin
         z_ff <= '0;
         unique case (cmd.sel)
            SEL_PHI: begin
               x_ff <= {4'b0000, abs_z, 8'h00};
               y_ff <= {4'b0000, root_ff};
            end
            SEL_THETA: begin
               x_ff <= {4'b0000, root_ff};
               y_ff <= {4'b0000, abs_x, 8'h00};
            end
            default: begin
               x_ff <= {4'b0000, root_ff};
               y_ff <= {4'b0000, abs_y, 8'h00};
            end
         endcase
      end else if (cmd.cor_step) begin
         x_ff <= x_ff + (y_mag >>> cmd.iter);
         if (!y_ff[27]) begin
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_w;
         end else begin
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_w;
         end
      end
   end

   // ---- angle rounding and storage
   logic signed [31:0] z_rnd;
   logic [15:0]        z_mag;
   logic signed [14:0] ang_val;
   always_comb begin
      z_rnd = z_ff + 32'sd32768;
      if (z_ff[31]) begin
         z_mag = '0;
      end else if (z_rnd[31:16] > QUARTER) begin
         z_mag = QUARTER;
      end else begin
         z_mag = z_rnd[31:16];
      end
      if (den_zero) begin
         ang_val = num_zero ? 15'sd0 : (num_neg ? -15'sd9000 : 15'sd9000);
      end else if (num_zero) begin
         ang_val = 15'sd0;
      end else begin
         ang_val = (num_neg ^ den_neg) ? -z_mag[14:0] : z_mag[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ang_ff[cmd.sel] <= ang_val;
      end
   end

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            cfg_ff[k] <= '0;
         end
      end else if (csr_write && (csr_index < 2'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // ---- offsets and results
   logic signed [15:0] corr   [3];
   logic signed [15:0] off_in [3];
   logic signed [15:0] res    [3];
   always_comb begin
      for (int k = 0; k < NUM_REGS; k++) begin
         corr[k] = sat_angle({{3{ang_ff[k][14]}}, ang_ff[k]}
                             + {{2{off_ff[k][15]}}, off_ff[k]});
         off_in[k] = off_ff[k];
         if (cmd_ff == CMD_CALIBRATE && corr[k] != '0) begin
            off_in[k] = sat_angle({{2{off_ff[k][15]}}, off_ff[k]}
                                  - {{2{corr[k][15]}}, corr[k]});
         end else if (cmd_ff == CMD_LOAD) begin
            off_in[k] = sat_angle({{2{cfg_ff[k][15]}}, cfg_ff[k]});
         end
         res[k] = corr[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            off_ff[k] <= '0;
         end
      end else if (cmd.apply) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            off_ff[k] <= off_in[k];
         end
      end
   end

   logic signed [14:0] temp_q;
   logic signed [15:0] temp_sum;
   assign temp_q   = temp_neg_ff ? -{1'b0, temp_prod_ff[33:20]} : {1'b0, temp_prod_ff[33:20]};
   assign temp_sum = {temp_q[14], temp_q} + TEMP_BIAS;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            out_ang_ff[k] <= res[k];
         end
         temp_out_ff <= temp_sum[14:0];
      end
   end

   assign rsp_phi_angle         = out_ang_ff[0];
   assign rsp_theta_angle       = out_ang_ff[1];
   assign rsp_psi_angle         = out_ang_ff[2];
   assign rsp_temperature_centi = temp_out_ff;

endmodule

// File: hdl/atau_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atau_controller
// sequencer for squares, square roots, cordic passes and result handoff
// ----------------------------------------------------------------------------
module atau_controller
   import atau_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  atau_status_type status,
   output atau_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQUARE = 4'd1;
   localparam logic [3:0] ST_SELECT = 4'd2;
   localparam logic [3:0] ST_ROOT   = 4'd3;
   localparam logic [3:0] ST_CINIT  = 4'd4;
   localparam logic [3:0] ST_ROTATE = 4'd5;
   localparam logic [3:0] ST_STORE  = 4'd6;
   localparam logic [3:0] ST_APPLY  = 4'd7;
   localparam logic [3:0] ST_RESULT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign out_free  = !(valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = '0;
      cmd.sq_idx = cnt_ff[1:0];
      cmd.iter   = cnt_ff;
      cmd.sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NUM_REGS - 1)) begin
               sel_in   = SEL_PHI;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            cnt_in = '0;
            if (status.trivial) begin
               state_in = ST_STORE;
            end else begin
               cmd.root_init = 1'b1;
               state_in      = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_STEPS - 1)) begin
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            cmd.cor_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.cor_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ANGLE_ITERATIONS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (sel_ff == SEL_PSI) begin
               state_in = ST_APPLY;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_SELECT;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= SEL_PHI;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> (state_ff == ST_IDLE))
      else $error("left idle without a transfer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> valid_ff)
      else $error("result loaded without valid");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff != 2'd3)
      else $error("angle select out of range");

endmodule

// File: tb/tb_accel_tilt_angle_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angle_unit_core
// self-checking bench for the tilt angle and temperature unit
// ----------------------------------------------------------------------------
// an in-bench angle predictor mirrors the square root, cordic, offset and
// temperature arithmetic; every request queues one expected reading and a
// checker process compares each rsp_ transfer with the oldest one. directed
// tests cover extremes, zero denominators, calibrate and load, then random
// samples run with random gaps on both channels over several offset settings
// ----------------------------------------------------------------------------
module tb_accel_tilt_angle_unit_core
   import atau_pkg::*;
();

   typedef struct {
      logic signed [15:0] phi;
      logic signed [15:0] theta;
      logic signed [15:0] psi;
      logic signed [14:0] temp;
   } reading_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic signed [15:0] req_accel_x;
   logic signed [15:0] req_accel_y;
   logic signed [15:0] req_accel_z;
   logic signed [15:0] req_temp_raw;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_phi_angle;
   logic signed [15:0] rsp_theta_angle;
   logic signed [15:0] rsp_psi_angle;
   logic signed [14:0] rsp_temperature_centi;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   // predictor state: config shadow and live offsets
   logic [15:0] shadow_regs [NUM_REGS];
   longint      offset_now [3];

   reading_type pending_readings [$];
   int          mismatch_count = 0;
   longint      cycle_count = 0;
   bit          stall_enable;
   bit          sender_gaps;

   localparam longint CYCLE_LIMIT = 2_000_000;

   accel_tilt_angle_unit_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint clamp_angle(input longint v);
      if (v > 18000) return 18000;
      if (v < -18000) return -18000;
      return v;
   endfunction

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v -= res + bit_pos;
            res = (res >> 1) + bit_pos;
         end else begin
            res >>= 1;
         end
         bit_pos >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint hypot_q8(input longint a, input longint b);
      longint unsigned s;
      s = longint'(a * a + b * b);
      return int_sqrt(s << 16);
   endfunction

   // single-argument arctangent in centidegrees via vectoring cordic
   function automatic longint tilt_centi(input longint num, input longint den);
      longint cx, cy, acc, dy, mag;
      bit neg;
      if (den == 0) return (num > 0) ? 9000 : ((num < 0) ? -9000 : 0);
      if (num == 0) return 0;
      neg = (num < 0) != (den < 0);
      cx = (den < 0) ? -den : den;
      cy = (num < 0) ? -num : num;
      acc = 0;
      for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
         dy = cx >>> i;
         mag = (cy < 0) ? -cy : cy;
         cx += mag >>> i;
         if (cy >= 0) begin
            cy -= dy;
            acc += longint'(atan_entry(i[4:0]));
         end else begin
            cy += dy;
            acc -= longint'(atan_entry(i[4:0]));
         end
      end
      acc = (acc >= 0) ? ((acc + 32768) >>> 16) : 0;
      if (acc > 9000) acc = 9000;
      return neg ? -acc : acc;
   endfunction

   function automatic reading_type predict_reading(input logic [1:0] cmd,
         input logic signed [15:0] ax, input logic signed [15:0] ay,
         input logic signed [15:0] az, input logic signed [15:0] tr);
      reading_type r;
      longint ang [3];
      longint c, t;
      ang[0] = tilt_centi(hypot_q8(ax, ay), longint'(az) * 256);
      ang[1] = tilt_centi(longint'(ax) * 256, hypot_q8(ay, az));
      ang[2] = tilt_centi(longint'(ay) * 256, hypot_q8(ax, az));
      if (cmd == CMD_CALIBRATE) begin
         for (int k = 0; k < 3; k++) begin
            c = clamp_angle(ang[k] + offset_now[k]);
            if (c != 0) offset_now[k] = clamp_angle(offset_now[k] - c);
         end
      end else if (cmd == CMD_LOAD) begin
         for (int k = 0; k < 3; k++)
            offset_now[k] = clamp_angle(longint'(signed'(shadow_regs[k])));
      end
      t = (longint'(tr) * 100) / 340 + 3653;
      r.phi   = 16'(clamp_angle(ang[0] + offset_now[0]));
      r.theta = 16'(clamp_angle(ang[1] + offset_now[1]));
      r.psi   = 16'(clamp_angle(ang[2] + offset_now[2]));
      r.temp  = 15'(t);
      return r;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic signed [15:0] rand_word();
      return 16'($urandom());
   endfunction

   // one request transfer, prediction queued at acceptance
   task automatic send_sample(input logic [1:0] cmd, input logic signed [15:0] ax,
         input logic signed [15:0] ay, input logic signed [15:0] az,
         input logic signed [15:0] tr);
      int g;
      g = sender_gaps ? gap_len() : 0;
      repeat (g) @(posedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_accel_x  <= ax;
      req_accel_y  <= ay;
      req_accel_z  <= az;
      req_temp_raw <= tr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(predict_reading(cmd, ax, ay, az, tr));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for drain, then let the block settle before touching registers
   task automatic wait_idle();
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_REGS) shadow_regs[idx] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_offsets(input logic [15:0] p, input logic [15:0] t,
         input logic [15:0] s);
      wait_idle();
      write_reg(REG_PHI_OFFSET, p);
      write_reg(REG_THETA_OFFSET, t);
      write_reg(REG_PSI_OFFSET, s);
      write_reg(2'(NUM_REGS), rand_word());
      send_sample(CMD_LOAD, rand_word(), rand_word(), rand_word(), rand_word());
   endtask

   task automatic test_extremes();
      logic signed [15:0] v [5];
      v = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
      foreach (v[i]) send_sample(CMD_MEASURE, v[i], v[(i + 1) % 5], v[(i + 2) % 5], v[i]);
      send_sample(CMD_MEASURE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh5555);
      send_sample(CMD_MEASURE, 16'sh8000, 16'sh8000, 16'sh8000, 16'shaaaa);
      send_sample(CMD_SPARE, 16'sd100, -16'sd200, 16'sd300, 16'sd0);
   endtask

   task automatic test_zero_axes();
      // zero denominators and zero numerators, both signs
      send_sample(CMD_MEASURE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd500, 16'sd0, 16'sd0, 16'sd0);
      send_sample(CMD_MEASURE, -16'sd500, 16'sd0, 16'sd0, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd0, 16'sd700, 16'sd0, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd0, -16'sd700, 16'sd0, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd0, 16'sd0, -16'sd900, 16'sd0);
   endtask

   task automatic test_offsets();
      load_offsets(16'd18000, -16'sd18000, 16'd0);
      send_sample(CMD_MEASURE, 16'sd1000, 16'sd2000, -16'sd3000, 16'sd340);
      send_sample(CMD_CALIBRATE, 16'sd1000, 16'sd2000, -16'sd3000, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd1000, 16'sd2000, -16'sd3000, 16'sd0);
      // out-of-range register values saturate on load
      load_offsets(16'h7fff, 16'h8000, 16'hb9b0);
      send_sample(CMD_CALIBRATE, 16'sd0, 16'sd0, 16'sd4000, 16'sd0);
      send_sample(CMD_MEASURE, 16'sd0, 16'sd0, 16'sd4000, 16'sd0);
   endtask

   task automatic test_random(input int count);
      int r;
      logic [1:0] cmd;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 19);
         cmd = (r < 14) ? CMD_MEASURE : (r < 17) ? CMD_CALIBRATE :
               (r < 19) ? CMD_LOAD : CMD_SPARE;
         if ($urandom_range(0, 9) == 0)
            send_sample(cmd, $urandom_range(0, 1) ? 16'sd0 : rand_word(),
                        $urandom_range(0, 1) ? 16'sd0 : rand_word(),
                        $urandom_range(0, 1) ? 16'sd0 : rand_word(), rand_word());
         else
            send_sample(cmd, rand_word(), rand_word(), rand_word(), rand_word());
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset || !stall_enable)
         rsp_stall <= 1'b0;
      else if ($urandom_range(0, 29) == 0)
         rsp_stall <= 1'b1;
      else if (rsp_stall && $urandom_range(0, 3) == 0)
         rsp_stall <= 1'b0;
      else if (!rsp_stall)
         rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // checker: every rsp_ transfer against the oldest expectation
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer");
         end else begin
            e = pending_readings.pop_front();
            if (e.phi !== rsp_phi_angle || e.theta !== rsp_theta_angle ||
                e.psi !== rsp_psi_angle || e.temp !== rsp_temperature_centi) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           e.phi, e.theta, e.psi, e.temp, rsp_phi_angle,
                           rsp_theta_angle, rsp_psi_angle, rsp_temperature_centi);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_MEASURE;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_temp_raw = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_enable = 1'b0;
      sender_gaps = 1'b0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (offset_now[i]) offset_now[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_zero_axes();
      stall_enable = 1'b1;
      sender_gaps = 1'b1;
      test_offsets();
      test_random(150);
      load_offsets(16'($urandom_range(0, 36000) - 18000), rand_word(), 16'd0);
      test_random(150);
      load_offsets(-16'sd18000, 16'd18000, 16'd18000);
      stall_enable = 1'b0;
      sender_gaps = 1'b0;
      test_random(60);
      stall_enable = 1'b1;
      sender_gaps = 1'b1;
      test_random(90);

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
